// File: rtl/gdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid distance field package
// Shared types and constants of the grid distance field engine: action codes,
// sequencer states, register indexes, edge masks and init values.
// ----------------------------------------------------------------------------
package gdf_pkg;

  // Action codes carried by a command transfer. Code 7 is unused and reports
  // the addressed cell like a read.
  typedef enum logic [2:0] {
    ACT_INIT  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_RELAX = 3'd2,
    ACT_FIND  = 3'd3,
    ACT_MARK  = 3'd4,
    ACT_SWAP  = 3'd5,
    ACT_READ  = 3'd6
  } action_t;

  // Sequencer states of the engine.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WR_DIST,
    S_HERE_RD,
    S_HERE_CAP,
    S_NB_RD,
    S_NB_CMP,
    S_NB_DONE,
    S_MK_RD,
    S_MK_WR,
    S_SWP_RD,
    S_SWP_WR,
    S_TAIL_RD,
    S_CAP
  } state_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;

  // Reset value of both size registers.
  localparam logic [7:0] CFG_RESET = 8'd128;

  // Values written by init_cell.
  localparam logic [15:0] DIST_OPEN    = 16'hFF00;
  localparam logic [15:0] DIST_BLOCKED = 16'hFFFF;

  // Neighbor scan order.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Edge bits of the walk mask per scan direction, set A and set B.
  localparam logic [7:0] EDGE_A [4] = '{8'h01, 8'h08, 8'h04, 8'h02};
  localparam logic [7:0] EDGE_B [4] = '{8'h10, 8'h80, 8'h40, 8'h20};

endpackage

// File: rtl/gdf_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid distance field channel interfaces
// Valid/ready channels for commands, results and configuration writes.
// ----------------------------------------------------------------------------
interface gdf_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [6:0]  cell_x;
  logic [6:0]  cell_y;
  logic [7:0]  walk_mask;
  logic        tile_blocked;
  logic [15:0] distance_value;

  modport source (
    output valid, action, cell_x, cell_y, walk_mask, tile_blocked, distance_value,
    input  ready
  );
  modport sink (
    input  valid, action, cell_x, cell_y, walk_mask, tile_blocked, distance_value,
    output ready
  );
endinterface

interface gdf_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [6:0]  found_x;
  logic [6:0]  found_y;
  logic [15:0] cell_distance;
  logic        pending_bit;

  modport source (
    output valid, hit, found_x, found_y, cell_distance, pending_bit,
    input  ready
  );
  modport sink (
    input  valid, hit, found_x, found_y, cell_distance, pending_bit,
    output ready
  );
endinterface

interface gdf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: rtl/grid_distance_field_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid distance field engine
// Distance grid with two frontier bitmaps, driven one command at a time by a
// small sequencer around a shared address, compare and increment unit.
// ----------------------------------------------------------------------------
// Usage: commands arrive on cmd, results leave on rsp, and the size registers
// are written on cfg (index 0 columns, index 1 rows; cfg is always ready and
// should only be written while no command is outstanding). Every command
// transfer yields exactly one result transfer, in order.
// Work per command: read_cell and code 7 only read the cell for the result;
// any other command but swap on a cell off the grid reports zeros; init_cell
// and write_distance first write the cell; relax and find read the cell, then
// each enabled neighbor in turn from the single distance memory port (relax
// writes the cell back on a smaller neighbor; find stops at its first
// match); mark_around reads and writes each window row, swap each used
// bitmap row. The result is registered and becomes valid in the same
// cycle in which the engine is ready for the next command.
// Reset clears the frontier bitmaps at once through per-row valid bits,
// selects bitmap A as current and loads 128 into both size registers; the
// distance grid is not cleared. A stalled receiver holds the result in the
// output register; the engine may take and work on one more command, then
// waits before loading the next result.
// ----------------------------------------------------------------------------
module grid_distance_field_engine #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 128
) (
  input logic       clk,
  input logic       rst,
  gdf_cfg_if.sink   cfg,
  gdf_cmd_if.sink   cmd,
  gdf_rsp_if.source rsp
);
  import gdf_pkg::*;

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int DAW   = $clog2(CELLS);
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam logic [7:0] COLS_LIMIT = 8'(MAX_COLUMNS);
  localparam logic [7:0] ROWS_LIMIT = 8'(MAX_ROWS);

  // Configuration and control state.
  logic [7:0]          grid_columns;
  logic [7:0]          grid_rows;
  state_t              state_q;
  state_t              state_next;
  logic                sel_q;
  logic [MAX_ROWS-1:0] vld_a;
  logic [MAX_ROWS-1:0] vld_b;
  logic                rsp_valid;

  // Latched command and working registers.
  logic [2:0]  act_q;
  logic [6:0]  x_q;
  logic [6:0]  y_q;
  logic [7:0]  walk_q;
  logic        blk_q;
  logic [15:0] dval_q;
  logic        inside_q;
  logic [15:0] best_q;
  logic        hit_q;
  logic [6:0]  fx_q;
  logic [6:0]  fy_q;
  logic [1:0]  dir_q;
  logic [6:0]  row_q;
  logic        va_q;
  logic        vb_q;

  // Result register.
  logic        rsp_hit;
  logic [6:0]  rsp_fx;
  logic [6:0]  rsp_fy;
  logic [15:0] rsp_dist;
  logic        rsp_pend;

  // Derived sizes and bounds.
  logic [7:0] cols_used;
  logic [7:0] rows_used;
  logic [7:0] full_cols;
  logic       cmd_inside;
  logic [6:0] left;
  logic [6:0] right;
  logic [6:0] top;
  logic [6:0] bottom;
  logic       last_row;

  // Neighbor selection, address and compare unit.
  logic [6:0]     nb_x;
  logic [6:0]     nb_y;
  logic           nb_in;
  logic           nb_ok;
  logic [6:0]     ax;
  logic [6:0]     ay;
  logic [14:0]    lin;
  logic [DAW-1:0] dist_addr;
  logic           cmp_lt;
  logic           cmp_eq;
  logic [15:0]    best_inc;

  // Memory controls.
  logic                   cmd_ready;
  logic                   dist_we;
  logic [15:0]            dist_wd;
  logic                   dist_re;
  logic [15:0]            dist_rd;
  logic                   bm_a_we;
  logic                   bm_b_we;
  logic [MAX_COLUMNS-1:0] bm_a_wd;
  logic [MAX_COLUMNS-1:0] bm_b_wd;
  logic                   bm_re;
  logic [RW-1:0]          bm_raddr;
  logic [MAX_COLUMNS-1:0] bm_a_rd;
  logic [MAX_COLUMNS-1:0] bm_b_rd;
  logic [MAX_COLUMNS-1:0] row_a;
  logic [MAX_COLUMNS-1:0] row_b;
  logic [MAX_COLUMNS-1:0] cur_row;
  logic [MAX_COLUMNS-1:0] mark_mask;
  logic [MAX_COLUMNS-1:0] keep_mask;
  logic                   rsp_load;

  logic cmd_fire;
  logic cfg_fire;

  assign cmd_fire  = cmd.valid && cmd_ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;
  assign cmd.ready = cmd_ready;

  assign rsp.valid         = rsp_valid;
  assign rsp.hit           = rsp_hit;
  assign rsp.found_x       = rsp_fx;
  assign rsp.found_y       = rsp_fy;
  assign rsp.cell_distance = rsp_dist;
  assign rsp.pending_bit   = rsp_pend;

  // A size of zero counts as one, and sizes are capped at the grid limits.
  always_comb begin
    if (grid_columns == 8'd0) begin
      cols_used = 8'd1;
    end else if (grid_columns > COLS_LIMIT) begin
      cols_used = COLS_LIMIT;
    end else begin
      cols_used = grid_columns;
    end
    if (grid_rows == 8'd0) begin
      rows_used = 8'd1;
    end else if (grid_rows > ROWS_LIMIT) begin
      rows_used = ROWS_LIMIT;
    end else begin
      rows_used = grid_rows;
    end
    full_cols  = {cols_used[7:3], 3'b000};
    cmd_inside = ({1'b0, cmd.cell_x} < cols_used) && ({1'b0, cmd.cell_y} < rows_used);
  end

  // The 3x3 window around the cell, clipped to the grid in use.
  always_comb begin
    left     = (x_q != 7'd0) ? x_q - 7'd1 : x_q;
    right    = (({1'b0, x_q} + 8'd1) < cols_used) ? x_q + 7'd1 : x_q;
    top      = (y_q != 7'd0) ? y_q - 7'd1 : y_q;
    bottom   = (({1'b0, y_q} + 8'd1) < rows_used) ? y_q + 7'd1 : y_q;
    last_row = ({1'b0, row_q} == (rows_used - 8'd1));
  end

  // Neighbor in the current scan direction and whether it takes part.
  always_comb begin
    nb_x  = x_q;
    nb_y  = y_q;
    nb_in = 1'b0;
    unique case (dir_q)
      DIR_UP: begin
        nb_y  = y_q - 7'd1;
        nb_in = (y_q != 7'd0);
      end
      DIR_LEFT: begin
        nb_x  = x_q - 7'd1;
        nb_in = (x_q != 7'd0);
      end
      DIR_RIGHT: begin
        nb_x  = x_q + 7'd1;
        nb_in = (({1'b0, x_q} + 8'd1) < cols_used);
      end
      DIR_DOWN: begin
        nb_y  = y_q + 7'd1;
        nb_in = (({1'b0, y_q} + 8'd1) < rows_used);
      end
      default: begin
        nb_in = 1'b0;
      end
    endcase
    // Find only checks edge set A; relax needs both sets.
    nb_ok = nb_in && ((walk_q & EDGE_A[dir_q]) != 8'd0) &&
            ((act_q == ACT_FIND) || ((walk_q & EDGE_B[dir_q]) != 8'd0));
  end

  // Shared unit: one cell address multiplier, two comparators, one incrementer.
  always_comb begin
    ax        = (state_q == S_NB_RD) ? nb_x : x_q;
    ay        = (state_q == S_NB_RD) ? nb_y : y_q;
    lin       = 15'(ay) * 15'(MAX_COLUMNS) + 15'(ax);
    dist_addr = lin[DAW-1:0];
    cmp_lt    = (dist_rd < best_q);
    cmp_eq    = (dist_rd == dval_q);
    best_inc  = best_q + 16'd1;
  end

  // Bitmap rows that were never written since reset read as zero.
  always_comb begin
    row_a   = bm_a_rd & {MAX_COLUMNS{va_q}};
    row_b   = bm_b_rd & {MAX_COLUMNS{vb_q}};
    cur_row = sel_q ? row_b : row_a;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      mark_mask[c] = (8'(c) >= {1'b0, left}) && (8'(c) <= {1'b0, right}) &&
                     !((row_q == y_q) && (8'(c) == {1'b0, x_q}));
      keep_mask[c] = (8'(c) >= full_cols);
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (act_q == ACT_SWAP) begin
          state_next = S_SWP_RD;
        end else if (!inside_q) begin
          state_next = S_TAIL_RD;
        end else if ((act_q == ACT_INIT) || (act_q == ACT_WRITE)) begin
          state_next = S_WR_DIST;
        end else if ((act_q == ACT_RELAX) || (act_q == ACT_FIND)) begin
          state_next = S_HERE_RD;
        end else if (act_q == ACT_MARK) begin
          state_next = S_MK_RD;
        end else begin
          state_next = S_TAIL_RD;
        end
      end
      S_WR_DIST:  state_next = S_TAIL_RD;
      S_HERE_RD:  state_next = S_HERE_CAP;
      S_HERE_CAP: state_next = S_NB_RD;
      S_NB_RD: begin
        priority if (nb_ok) begin
          state_next = S_NB_CMP;
        end else if (dir_q == DIR_DOWN) begin
          state_next = S_NB_DONE;
        end else begin
          state_next = S_NB_RD;
        end
      end
      S_NB_CMP: begin
        priority if ((act_q == ACT_FIND) && cmp_eq) begin
          state_next = S_TAIL_RD;
        end else if (dir_q == DIR_DOWN) begin
          state_next = S_NB_DONE;
        end else begin
          state_next = S_NB_RD;
        end
      end
      S_NB_DONE: begin
        state_next = ((act_q == ACT_RELAX) && hit_q) ? S_WR_DIST : S_TAIL_RD;
      end
      S_MK_RD: state_next = S_MK_WR;
      S_MK_WR: state_next = (row_q == bottom) ? S_TAIL_RD : S_MK_RD;
      S_SWP_RD: state_next = S_SWP_WR;
      S_SWP_WR: state_next = last_row ? S_TAIL_RD : S_SWP_RD;
      S_TAIL_RD: state_next = S_CAP;
      S_CAP: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    cmd_ready = 1'b0;
    dist_we   = 1'b0;
    dist_wd   = best_inc;
    dist_re   = 1'b0;
    bm_a_we   = 1'b0;
    bm_b_we   = 1'b0;
    bm_a_wd   = row_a | mark_mask;
    bm_b_wd   = row_b | mark_mask;
    bm_re     = 1'b0;
    bm_raddr  = (state_q == S_TAIL_RD) ? y_q[RW-1:0] : row_q[RW-1:0];
    rsp_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_ready = 1'b1;
      end
      S_WR_DIST: begin
        dist_we = 1'b1;
        if (act_q == ACT_INIT) begin
          dist_wd = blk_q ? DIST_BLOCKED : DIST_OPEN;
        end else if (act_q == ACT_WRITE) begin
          dist_wd = dval_q;
        end else begin
          dist_wd = best_inc;
        end
      end
      S_HERE_RD: begin
        dist_re = 1'b1;
      end
      S_NB_RD: begin
        dist_re = nb_ok;
      end
      S_MK_RD, S_SWP_RD: begin
        bm_re = 1'b1;
      end
      S_MK_WR: begin
        bm_a_we = 1'b1;
        bm_b_we = 1'b1;
      end
      S_SWP_WR: begin
        // Clear whole bytes of the non-current bitmap; a trailing partial
        // byte of the row keeps its bits.
        bm_a_wd = row_a & keep_mask;
        bm_b_wd = row_b & keep_mask;
        bm_a_we = sel_q;
        bm_b_we = !sel_q;
      end
      S_TAIL_RD: begin
        dist_re = inside_q;
        bm_re   = inside_q;
      end
      S_CAP: begin
        rsp_load = !rsp_valid || rsp.ready;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q      <= S_IDLE;
      sel_q        <= 1'b0;
      vld_a        <= '0;
      vld_b        <= '0;
      rsp_valid    <= 1'b0;
      grid_columns <= CFG_RESET;
      grid_rows    <= CFG_RESET;
    end else begin
      state_q <= state_next;
      if (cfg_fire) begin
        unique case (cfg.index)
          CFG_COLUMNS: grid_columns <= cfg.data;
          CFG_ROWS:    grid_rows    <= cfg.data;
          default:     grid_rows    <= grid_rows;
        endcase
      end
      if (bm_a_we) begin
        vld_a[row_q[RW-1:0]] <= 1'b1;
      end
      if (bm_b_we) begin
        vld_b[row_q[RW-1:0]] <= 1'b1;
      end
      // The selection flips once the last row of the other bitmap is cleared.
      if ((state_q == S_SWP_WR) && last_row) begin
        sel_q <= !sel_q;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      act_q    <= cmd.action;
      x_q      <= cmd.cell_x;
      y_q      <= cmd.cell_y;
      walk_q   <= cmd.walk_mask;
      blk_q    <= cmd.tile_blocked;
      dval_q   <= cmd.distance_value;
      inside_q <= cmd_inside;
      hit_q    <= 1'b0;
      fx_q     <= 7'd0;
      fy_q     <= 7'd0;
    end
    if (bm_re) begin
      va_q <= vld_a[bm_raddr];
      vb_q <= vld_b[bm_raddr];
    end
    unique case (state_q)
      S_DISPATCH: begin
        row_q <= (act_q == ACT_SWAP) ? 7'd0 : top;
      end
      S_HERE_CAP: begin
        best_q <= dist_rd;
        dir_q  <= DIR_UP;
      end
      S_NB_RD: begin
        if (!nb_ok) begin
          dir_q <= dir_q + 2'd1;
        end
      end
      S_NB_CMP: begin
        if ((act_q == ACT_RELAX) && cmp_lt) begin
          best_q <= dist_rd;
          hit_q  <= 1'b1;
        end
        if ((act_q == ACT_FIND) && cmp_eq) begin
          hit_q <= 1'b1;
          fx_q  <= nb_x;
          fy_q  <= nb_y;
        end
        dir_q <= dir_q + 2'd1;
      end
      S_MK_WR, S_SWP_WR: begin
        row_q <= row_q + 7'd1;
      end
      default: begin
        row_q <= row_q;
      end
    endcase
    if (rsp_load) begin
      rsp_hit  <= hit_q;
      rsp_fx   <= fx_q;
      rsp_fy   <= fy_q;
      rsp_dist <= inside_q ? dist_rd : 16'd0;
      rsp_pend <= inside_q ? cur_row[x_q[CW-1:0]] : 1'b0;
    end
  end

  // Distance grid, one word per cell.
  gdf_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_dist (
    .clk     (clk),
    .wr_en   (dist_we),
    .wr_addr (dist_addr),
    .wr_data (dist_wd),
    .rd_en   (dist_re),
    .rd_addr (dist_addr),
    .rd_data (dist_rd)
  );

  // Frontier bitmaps, one row of cells per word.
  gdf_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_bm_a (
    .clk     (clk),
    .wr_en   (bm_a_we),
    .wr_addr (row_q[RW-1:0]),
    .wr_data (bm_a_wd),
    .rd_en   (bm_re),
    .rd_addr (bm_raddr),
    .rd_data (bm_a_rd)
  );

  gdf_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_bm_b (
    .clk     (clk),
    .wr_en   (bm_b_we),
    .wr_addr (row_q[RW-1:0]),
    .wr_data (bm_b_wd),
    .rd_en   (bm_re),
    .rd_addr (bm_raddr),
    .rd_data (bm_b_rd)
  );

endmodule

// File: rtl/gdf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Read data holds while no read is issued.
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/gdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid distance field port checker
// Watches the engine's ports: one result per command, bounded occupancy,
// result register behavior.
// ----------------------------------------------------------------------------
module gdf_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_hit,
  input logic [6:0] rsp_found_x,
  input logic [6:0] rsp_found_y
);

  logic       cmd_fire;
  logic       rsp_fire;
  logic [1:0] outstanding;

  assign cmd_fire = cmd_valid && cmd_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 2'd0;
    end else if (cmd_fire && !rsp_fire) begin
      outstanding <= outstanding + 2'd1;
    end else if (rsp_fire && !cmd_fire) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> !cmd_ready)
    else $error("command taken while the previous one is still in work");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> (outstanding != 2'd0))
    else $error("result transfer without an outstanding command");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more than two commands outstanding");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_hit) |-> ((rsp_found_x == 7'd0) && (rsp_found_y == 7'd0)))
    else $error("found position reported without a hit");

endmodule

bind grid_distance_field_engine gdf_checker u_gdf_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_hit     (rsp.hit),
  .rsp_found_x (rsp.found_x),
  .rsp_found_y (rsp.found_y)
);

// File: tb/gdf_distance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid distance field result checker
// Watches the configuration, command and result channels, keeps its own copy
// of the distance grid, frontier bitmaps and size registers, and compares
// each result transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module gdf_distance_checker (
  input  logic clk,
  input  logic rst,
  gdf_cfg_if   cfg,
  gdf_cmd_if   cmd,
  gdf_rsp_if   rsp,
  output int   fail_count,
  output int   open_count
);
  import gdf_pkg::*;

  localparam int GRID_COLS = 128;
  localparam int GRID_ROWS = 128;
  localparam int CELLS     = GRID_COLS * GRID_ROWS;

  // Neighbor offsets in scan order: up, left, right, down.
  localparam int STEP_X [4] = '{0, -1, 1, 0};
  localparam int STEP_Y [4] = '{-1, 0, 0, 1};

  typedef struct packed {
    logic        hit;
    logic [6:0]  found_x;
    logic [6:0]  found_y;
    logic [15:0] cell_distance;
    logic        pending_bit;
  } cell_report_t;

  logic [15:0]  dist_mem [CELLS];
  bit           frontier [2][CELLS];
  bit           front_sel;
  logic [7:0]   cols_reg;
  logic [7:0]   rows_reg;
  cell_report_t expected_q [$];
  cell_report_t want;
  cell_report_t got;
  string        bad;
  int           result_count;

  function automatic int grid_span(logic [7:0] r, int cap);
    if (r == 8'd0) return 1;
    if (int'(r) > cap) return cap;
    return int'(r);
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Applies one command to the shadow state and returns the result it gives.
  function automatic cell_report_t apply_command(action_t act, int x, int y,
                                                 logic [7:0] walk, logic blocked,
                                                 logic [15:0] dv);
    int           cols, rows, here, nx, ny, full, d, r, c;
    int           lo_x, hi_x, lo_y, hi_y;
    logic [15:0]  best, nd;
    bit           is_in, changed;
    cell_report_t rep;
    cols    = grid_span(cols_reg, GRID_COLS);
    rows    = grid_span(rows_reg, GRID_ROWS);
    is_in   = (x < cols) && (y < rows);
    here    = y * GRID_COLS + x;
    rep     = '0;
    changed = 1'b0;
    if (act == ACT_SWAP) begin
      // Only whole bytes of each used row are cleared in the other bitmap.
      full = (cols / 8) * 8;
      for (r = 0; r < rows; r++)
        for (c = 0; c < full; c++)
          frontier[!front_sel][r * GRID_COLS + c] = 1'b0;
      front_sel = !front_sel;
    end else if (is_in) begin
      case (act)
        ACT_INIT:  dist_mem[here] = blocked ? DIST_BLOCKED : DIST_OPEN;
        ACT_WRITE: dist_mem[here] = dv;
        ACT_RELAX, ACT_FIND: begin
          best = dist_mem[here];
          for (d = 0; d < 4; d++) begin
            nx = x + STEP_X[d];
            ny = y + STEP_Y[d];
            if ((walk & EDGE_A[d]) == 8'h00) continue;
            if (act == ACT_RELAX && (walk & EDGE_B[d]) == 8'h00) continue;
            if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
            nd = dist_mem[ny * GRID_COLS + nx];
            if (act == ACT_RELAX) begin
              if (nd < best) begin
                best    = nd;
                changed = 1'b1;
              end
            end else if (nd == dv) begin
              changed     = 1'b1;
              rep.found_x = 7'(nx);
              rep.found_y = 7'(ny);
              break;
            end
          end
          rep.hit = changed;
          if (act == ACT_RELAX && changed) dist_mem[here] = best + 16'd1;
        end
        ACT_MARK: begin
          lo_x = (x > 0) ? x - 1 : x;
          hi_x = (x < cols - 1) ? x + 1 : x;
          lo_y = (y > 0) ? y - 1 : y;
          hi_y = (y < rows - 1) ? y + 1 : y;
          for (r = lo_y; r <= hi_y; r++)
            for (c = lo_x; c <= hi_x; c++)
              if (c != x || r != y) begin
                frontier[0][r * GRID_COLS + c] = 1'b1;
                frontier[1][r * GRID_COLS + c] = 1'b1;
              end
        end
        default: ;
      endcase
    end
    if (is_in) begin
      rep.cell_distance = dist_mem[here];
      rep.pending_bit   = frontier[front_sel][here];
    end
    return rep;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        frontier[0][i] = 1'b0;
        frontier[1][i] = 1'b0;
      end
      front_sel    = 1'b0;
      cols_reg     = CFG_RESET;
      rows_reg     = CFG_RESET;
      fail_count   = 0;
      result_count = 0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_COLUMNS) cols_reg = cfg.data;
        else if (cfg.index == CFG_ROWS) rows_reg = cfg.data;
      end
      // A result leaving at this edge belongs to an earlier command, so it is
      // checked before the command taken at the same edge is predicted.
      if (rsp.valid && rsp.ready) begin
        got.hit           = rsp.hit;
        got.found_x       = rsp.found_x;
        got.found_y       = rsp.found_y;
        got.cell_distance = rsp.cell_distance;
        got.pending_bit   = rsp.pending_bit;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no command waiting",
                                    result_count));
        end else begin
          want = expected_q.pop_front();
          bad  = "";
          if (got.hit !== want.hit)
            bad = {bad, $sformatf(" hit %0b/%0b", got.hit, want.hit)};
          if (got.found_x !== want.found_x)
            bad = {bad, $sformatf(" found_x %0d/%0d", got.found_x, want.found_x)};
          if (got.found_y !== want.found_y)
            bad = {bad, $sformatf(" found_y %0d/%0d", got.found_y, want.found_y)};
          if (got.cell_distance !== want.cell_distance)
            bad = {bad, $sformatf(" cell_distance %h/%h", got.cell_distance,
                                  want.cell_distance)};
          if (got.pending_bit !== want.pending_bit)
            bad = {bad, $sformatf(" pending_bit %0b/%0b", got.pending_bit,
                                  want.pending_bit)};
          if (bad != "")
            report_mismatch($sformatf("result %0d (got/expected):%s", result_count, bad));
        end
        result_count++;
      end
      if (cmd.valid && cmd.ready)
        expected_q.push_back(apply_command(action_t'(cmd.action), int'(cmd.cell_x),
                                           int'(cmd.cell_y), cmd.walk_mask,
                                           cmd.tile_blocked, cmd.distance_value));
    end
    open_count = expected_q.size();
  end

endmodule

// File: tb/tb_grid_distance_field_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid distance field engine testbench
// Drives a directed command sequence and then random commands through a set
// of grid sizes, with random gaps on the command side and random stalls on
// the result side. A checker beside the engine predicts and compares every
// result; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_grid_distance_field_engine;
  import gdf_pkg::*;

  localparam int GRID_COLS     = 128;
  localparam int GRID_ROWS     = 128;
  localparam int CELLS         = GRID_COLS * GRID_ROWS;
  localparam int RESET_CYCLES  = 11;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 90;
  localparam int DIRECTED      = 21;
  localparam int PLANNED_ITEMS = DIRECTED + PHASES * PHASE_ITEMS;
  // The limit covers the slowest command, a swap over 128 rows, and long
  // random stalls on the result side.
  localparam int STALL_LIMIT   = 4000;
  // Quiet cycles after the last result before a size change, and at the end.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 32;

  // Action code 7 has no function; the engine reports the cell as for a read.
  localparam action_t ACT_UNUSED = action_t'(3'd7);

  localparam int STEP_X [4] = '{0, -1, 1, 0};
  localparam int STEP_Y [4] = '{-1, 0, 0, 1};

  // Grid sizes per random phase. Zero stands for one, and anything above 128
  // stands for 128; widths not a multiple of eight leave a partial byte per row.
  localparam logic [7:0] PHASE_COLS [PHASES] = '{8'd0, 8'd13, 8'd255, 8'd8,
                                                 8'd1, 8'd128, 8'd21, 8'd200};
  localparam logic [7:0] PHASE_ROWS [PHASES] = '{8'd0, 8'd9, 8'd255, 8'd5,
                                                 8'd128, 8'd1, 8'd17, 8'd3};

  typedef struct packed {
    action_t     action;
    logic [6:0]  cell_x;
    logic [6:0]  cell_y;
    logic [7:0]  walk_mask;
    logic        tile_blocked;
    logic [15:0] distance_value;
  } grid_cmd_t;

  logic clk;
  logic rst;

  gdf_cfg_if cfg_ch ();
  gdf_cmd_if cmd_ch ();
  gdf_rsp_if rsp_ch ();

  int         fail_count;
  int         open_count;
  int         src_idle_pct = 38;
  int         dst_idle_pct = 81;
  int         issued       = 0;
  int         quiet_cycles = 0;
  logic [7:0] cols_set;
  logic [7:0] rows_set;
  // Cells whose distance has been written; nothing may read any other cell.
  bit         cell_set [CELLS];

  grid_distance_field_engine #(
    .MAX_COLUMNS(GRID_COLS),
    .MAX_ROWS   (GRID_ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  gdf_distance_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .fail_count(fail_count),
    .open_count(open_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The result side stalls at random, at the rate of the current idling mode.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Watchdog: counts quiet cycles, in which no channel moves a transfer, and
  // declares the run hung once the count reaches STALL_LIMIT.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("grid_distance_field_engine verification failed");
        $finish;
      end
    end
  end

  // Same clamping of the size registers as the engine applies.
  function automatic int grid_span(logic [7:0] r, int cap);
    if (r == 8'd0) return 1;
    if (int'(r) > cap) return cap;
    return int'(r);
  endfunction

  // A random command. Distances are drawn half the time from a small range so that
  // relax finds smaller neighbors and find meets its target often.
  function automatic grid_cmd_t random_cmd();
    grid_cmd_t  c;
    int         cols, rows, pick;
    logic [3:0] nib;
    cols = grid_span(cols_set, GRID_COLS);
    rows = grid_span(rows_set, GRID_ROWS);
    pick = $urandom_range(99);
    if (pick < 8)       c.action = ACT_INIT;
    else if (pick < 25) c.action = ACT_WRITE;
    else if (pick < 50) c.action = ACT_RELAX;
    else if (pick < 70) c.action = ACT_FIND;
    else if (pick < 80) c.action = ACT_MARK;
    else if (pick < 87) c.action = ACT_SWAP;
    else if (pick < 97) c.action = ACT_READ;
    else                c.action = ACT_UNUSED;
    // One command in ten may address a cell outside the grid in use.
    if ($urandom_range(9) == 0) begin
      c.cell_x = 7'($urandom_range(GRID_COLS - 1));
      c.cell_y = 7'($urandom_range(GRID_ROWS - 1));
    end else begin
      c.cell_x = 7'($urandom_range(cols - 1));
      c.cell_y = 7'($urandom_range(rows - 1));
    end
    // Relax needs both edge sets of a direction, so mostly mirror them.
    nib = 4'($urandom_range(15));
    if (c.action == ACT_RELAX && $urandom_range(9) < 7) c.walk_mask = {nib, nib};
    else c.walk_mask = 8'($urandom_range(255));
    c.tile_blocked = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick < 5)       c.distance_value = 16'($urandom_range(15));
    else if (pick == 5) c.distance_value = DIST_OPEN;
    else if (pick == 6) c.distance_value = DIST_BLOCKED;
    else                c.distance_value = 16'($urandom);
    return c;
  endfunction

  // A command that would read a distance never written is turned into an
  // initialization or seed of that cell instead, which fills the grid as the
  // run goes on. Relax and find are held to the same rule for every enabled neighbor.
  function automatic grid_cmd_t make_legal(grid_cmd_t c);
    int cols, rows, x, y, d, nx, ny;
    cols = grid_span(cols_set, GRID_COLS);
    rows = grid_span(rows_set, GRID_ROWS);
    x    = int'(c.cell_x);
    y    = int'(c.cell_y);
    if (x >= cols || y >= rows) return c;
    if (c.action != ACT_INIT && c.action != ACT_WRITE && !cell_set[y * GRID_COLS + x]) begin
      c.action = ($urandom_range(1) == 0) ? ACT_INIT : ACT_WRITE;
      return c;
    end
    if (c.action == ACT_RELAX || c.action == ACT_FIND) begin
      for (d = 0; d < 4; d++) begin
        nx = x + STEP_X[d];
        ny = y + STEP_Y[d];
        if ((c.walk_mask & EDGE_A[d]) == 8'h00) continue;
        if (c.action == ACT_RELAX && (c.walk_mask & EDGE_B[d]) == 8'h00) continue;
        if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
        if (!cell_set[ny * GRID_COLS + nx]) begin
          c.action = ($urandom_range(1) == 0) ? ACT_INIT : ACT_WRITE;
          c.cell_x = 7'(nx);
          c.cell_y = 7'(ny);
          return c;
        end
      end
    end
    return c;
  endfunction

  // Sends one command and returns at the edge of its transfer. The idling
  // mode follows the progress of the run: first a slow sender against a
  // slower receiver, then the reverse, then full rate on both sides.
  task automatic issue(input grid_cmd_t c);
    if (issued < PLANNED_ITEMS / 3) begin
      src_idle_pct = 38;
      dst_idle_pct = 81;
    end else if (issued < 2 * PLANNED_ITEMS / 3) begin
      src_idle_pct = 81;
      dst_idle_pct = 38;
    end else begin
      src_idle_pct = 0;
      dst_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.action         <= c.action;
    cmd_ch.cell_x         <= c.cell_x;
    cmd_ch.cell_y         <= c.cell_y;
    cmd_ch.walk_mask      <= c.walk_mask;
    cmd_ch.tile_blocked   <= c.tile_blocked;
    cmd_ch.distance_value <= c.distance_value;
    do @(posedge clk); while (!cmd_ch.ready);
    if ((c.action == ACT_INIT || c.action == ACT_WRITE) &&
        int'(c.cell_x) < grid_span(cols_set, GRID_COLS) &&
        int'(c.cell_y) < grid_span(rows_set, GRID_ROWS))
      cell_set[int'(c.cell_y) * GRID_COLS + int'(c.cell_x)] = 1'b1;
    issued++;
  endtask

  // Stops sending and waits until every result has come back, then waits out
  // the settle count given by the caller.
  task automatic drain_results(input int settle);
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes both size registers back to back; valid stays high between them.
  task automatic set_grid_size(input logic [7:0] cols, input logic [7:0] rows);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_COLUMNS;
    cfg_ch.data  <= cols;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_ROWS;
    cfg_ch.data  <= rows;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cols_set = cols;
    rows_set = rows;
  endtask

  initial begin
    rst                   = 1'b1;
    cmd_ch.valid          = 1'b0;
    cmd_ch.action         = ACT_READ;
    cmd_ch.cell_x         = 7'd0;
    cmd_ch.cell_y         = 7'd0;
    cmd_ch.walk_mask      = 8'h00;
    cmd_ch.tile_blocked   = 1'b0;
    cmd_ch.distance_value = 16'h0000;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_COLUMNS;
    cfg_ch.data           = 8'd0;
    cols_set              = CFG_RESET;
    rows_set              = CFG_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence on the full 128 x 128 grid left by reset. The first
    // cells are seeded so that every later read touches written cells only.
    issue(grid_cmd_t'{ACT_INIT,   7'd0,   7'd0,   8'h00, 1'b0, 16'h0000});
    issue(grid_cmd_t'{ACT_INIT,   7'd127, 7'd127, 8'hFF, 1'b1, 16'hFFFF});
    issue(grid_cmd_t'{ACT_WRITE,  7'd1,   7'd0,   8'h00, 1'b0, 16'h0005});
    issue(grid_cmd_t'{ACT_WRITE,  7'd0,   7'd1,   8'h00, 1'b0, 16'hFFFF});
    issue(grid_cmd_t'{ACT_WRITE,  7'd1,   7'd1,   8'h00, 1'b0, 16'h0000});
    // Corner relax: up and left are off the grid, the right neighbor wins.
    issue(grid_cmd_t'{ACT_RELAX,  7'd0,   7'd0,   8'hFF, 1'b0, 16'h0000});
    // Find skips the right neighbor and stops at the one below.
    issue(grid_cmd_t'{ACT_FIND,   7'd0,   7'd0,   8'h0F, 1'b0, 16'hFFFF});
    // No edge bits at all: find reports nothing.
    issue(grid_cmd_t'{ACT_FIND,   7'd0,   7'd0,   8'h00, 1'b0, 16'h0005});
    // Neighbors up and left are all larger, so relax leaves the cell alone.
    issue(grid_cmd_t'{ACT_RELAX,  7'd1,   7'd1,   8'h99, 1'b0, 16'h0000});
    // Only edge set A is open, which relax does not accept.
    issue(grid_cmd_t'{ACT_RELAX,  7'd1,   7'd1,   8'h0F, 1'b0, 16'h0000});
    issue(grid_cmd_t'{ACT_FIND,   7'd0,   7'd1,   8'h05, 1'b0, 16'h0000});
    // Far corner: the only open edges lead off the grid.
    issue(grid_cmd_t'{ACT_RELAX,  7'd127, 7'd127, 8'h66, 1'b0, 16'h0000});
    issue(grid_cmd_t'{ACT_FIND,   7'd127, 7'd127, 8'h66, 1'b0, 16'hFFFF});
    // Marking at both corners exercises the window clipping.
    issue(grid_cmd_t'{ACT_MARK,   7'd0,   7'd0,   8'h00, 1'b0, 16'h0000});
    issue(grid_cmd_t'{ACT_READ,   7'd1,   7'd1,   8'h00, 1'b0, 16'h0000});
    issue(grid_cmd_t'{ACT_MARK,   7'd127, 7'd127, 8'h00, 1'b0, 16'h0000});
    issue(grid_cmd_t'{ACT_SWAP,   7'd0,   7'd0,   8'h00, 1'b0, 16'h0000});
    issue(grid_cmd_t'{ACT_READ,   7'd1,   7'd0,   8'h00, 1'b0, 16'h0000});
    issue(grid_cmd_t'{ACT_UNUSED, 7'd1,   7'd1,   8'hFF, 1'b1, 16'hFFFF});
    issue(grid_cmd_t'{ACT_SWAP,   7'd127, 7'd127, 8'hFF, 1'b1, 16'hFFFF});
    issue(grid_cmd_t'{ACT_READ,   7'd0,   7'd1,   8'h00, 1'b0, 16'h0000});

    // Random phases, one grid size each. Sizes change only while the engine
    // has nothing outstanding.
    for (int p = 0; p < PHASES; p++) begin
      drain_results(SETTLE_CYCLES);
      set_grid_size(PHASE_COLS[p], PHASE_ROWS[p]);
      repeat (PHASE_ITEMS) issue(make_legal(random_cmd()));
    end

    drain_results(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("grid_distance_field_engine verification clean");
    end else begin
      $display("grid_distance_field_engine verification failed");
    end
    $finish;
  end

endmodule
